// ===== src/smm_pkg.sv =====
// shared types and constants of the segment model matrix pipeline
`default_nettype none
package smm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIR_W         = 33;
  localparam int NRM_W         = 30;
  localparam int NORM_BIT      = 29;
  localparam int SQ_IN_W       = 62;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] radial_scale;
    logic signed [31:0] length_scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] radial_scale;
    logic signed [31:0] length_scale;
  } side_t;

endpackage
`default_nettype wire

// ===== src/smm_delay.sv =====
// delay line with shared enable
`default_nettype none
module smm_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[D-1];

endmodule
`default_nettype wire

// ===== src/smm_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module smm_sqrt #(
  parameter int IN_W = 62
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     v,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;

  logic [IN_W-1:0]  rem_r  [OUT_W+1];
  logic [OUT_W-1:0] root_r [OUT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= v;
      root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < OUT_W; j++) begin : g_stage
    localparam int K = OUT_W - 1 - j;
    logic [IN_W:0] trial;
    assign trial = ((IN_W+1)'(root_r[j]) << (K + 1)) + ((IN_W+1)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_r[j]} >= trial) begin
          rem_r[j+1]  <= rem_r[j] - trial[IN_W-1:0];
          root_r[j+1] <= root_r[j] | (OUT_W'(1) << K);
        end else begin
          rem_r[j+1]  <= rem_r[j];
          root_r[j+1] <= root_r[j];
        end
      end
    end
  end

  assign root = root_r[OUT_W];

endmodule
`default_nettype wire

// ===== src/smm_div.sv =====
// pipelined fixed point divider, rounded half up on magnitudes
`default_nettype none
module smm_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 31,
  parameter int F     = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [F:0]       quo
);

  localparam int QW = F + 1;
  localparam int RMW = NUM_W + F + 1;

  logic [RMW-1:0]   rem_r [QW+1];
  logic [DEN_W-1:0] den_r [QW+1];
  logic [QW-1:0]    quo_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (RMW'(num) << F) + RMW'(den >> 1);
      den_r[0] <= den;
      quo_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [RMW-1:0] sub;
    assign sub = RMW'(den_r[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j+1] <= den_r[j];
        if (rem_r[j] >= sub) begin
          rem_r[j+1] <= rem_r[j] - sub;
          quo_r[j+1] <= quo_r[j] | (QW'(1) << K);
        end else begin
          rem_r[j+1] <= rem_r[j];
          quo_r[j+1] <= quo_r[j];
        end
      end
    end
  end

  assign quo = quo_r[QW];

endmodule
`default_nettype wire

// ===== src/smm_rot.sv =====
// rotation matrix assembly, scaling, rounding and saturation
`default_nettype none
module smm_rot import smm_pkg::*; #(
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [F+1:0] c,
  input  logic signed [F+1:0] s,
  input  logic signed [F+1:0] kx,
  input  logic signed [F+1:0] kz,
  input  logic                ident,
  input  side_t               side,
  output out_t                out_data
);

  localparam int CW  = F + 2;
  localparam int QW  = F + 3;
  localparam int RW  = F + 4;
  localparam int PW1 = 2 * F + 5;
  localparam int PW2 = RW + 32;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r = (mag + (64'(1) << (F - 1))) >> F;
    return p[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic signed [CW-1:0]  c1_r, s1_r, kx1_r, kz1_r;
  logic signed [QW-1:0]  w1_r;
  logic signed [CW-1:0]  c2_r, kx2_r, kz2_r;
  logic signed [PW1-1:0] pwkx2_r, pwkz2_r, pskz2_r, pskx2_r;
  logic signed [CW-1:0]  c3_r, kx3_r, kz3_r;
  logic signed [QW-1:0]  qwkx3_r, qwkz3_r, qskz3_r, qskx3_r;
  logic signed [CW-1:0]  c4_r;
  logic signed [QW-1:0]  qskz4_r, qskx4_r;
  logic signed [PW1-1:0] pxx4_r, pxz4_r, pzz4_r;
  logic signed [CW-1:0]  c5_r;
  logic signed [QW-1:0]  qskz5_r, qskx5_r, qxx5_r, qxz5_r, qzz5_r;
  logic signed [RW-1:0]  r6_r [3][3];
  logic signed [PW2-1:0] p7_r [3][3];
  side_t                 side6_r, side7_r;
  logic [$bits(side_t):0] side5;
  logic signed [31:0]    scl [3];
  logic signed [RW-1:0]  one_rw;
  out_t                  out_r;

  assign one_rw = RW'(1) <<< F;

  smm_delay #(.W($bits(side_t) + 1), .D(5)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   ({ident, side}),
    .q   (side5)
  );

  always_comb begin
    scl[0] = side6_r.radial_scale;
    scl[1] = side6_r.length_scale;
    scl[2] = side6_r.radial_scale;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c;
      s1_r  <= s;
      kx1_r <= kx;
      kz1_r <= kz;
      w1_r  <= (QW'(1) <<< F) - QW'(c);

      c2_r    <= c1_r;
      kx2_r   <= kx1_r;
      kz2_r   <= kz1_r;
      pwkx2_r <= PW1'(w1_r) * PW1'(kx1_r);
      pwkz2_r <= PW1'(w1_r) * PW1'(kz1_r);
      pskz2_r <= PW1'(s1_r) * PW1'(kz1_r);
      pskx2_r <= PW1'(s1_r) * PW1'(kx1_r);

      c3_r    <= c2_r;
      kx3_r   <= kx2_r;
      kz3_r   <= kz2_r;
      qwkx3_r <= QW'(rnd(64'(pwkx2_r)));
      qwkz3_r <= QW'(rnd(64'(pwkz2_r)));
      qskz3_r <= QW'(rnd(64'(pskz2_r)));
      qskx3_r <= QW'(rnd(64'(pskx2_r)));

      c4_r    <= c3_r;
      qskz4_r <= qskz3_r;
      qskx4_r <= qskx3_r;
      pxx4_r  <= PW1'(qwkx3_r) * PW1'(kx3_r);
      pxz4_r  <= PW1'(qwkx3_r) * PW1'(kz3_r);
      pzz4_r  <= PW1'(qwkz3_r) * PW1'(kz3_r);

      c5_r    <= c4_r;
      qskz5_r <= qskz4_r;
      qskx5_r <= qskx4_r;
      qxx5_r  <= QW'(rnd(64'(pxx4_r)));
      qxz5_r  <= QW'(rnd(64'(pxz4_r)));
      qzz5_r  <= QW'(rnd(64'(pzz4_r)));

      side6_r <= side5[$bits(side_t)-1:0];
      if (side5[$bits(side_t)]) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            r6_r[i][j] <= (i == j) ? one_rw : '0;
          end
        end
      end else begin
        r6_r[0][0] <= RW'(c5_r) + RW'(qxx5_r);
        r6_r[0][1] <= -RW'(qskz5_r);
        r6_r[0][2] <= RW'(qxz5_r);
        r6_r[1][0] <= RW'(qskz5_r);
        r6_r[1][1] <= RW'(c5_r);
        r6_r[1][2] <= -RW'(qskx5_r);
        r6_r[2][0] <= RW'(qxz5_r);
        r6_r[2][1] <= RW'(qskx5_r);
        r6_r[2][2] <= RW'(c5_r) + RW'(qzz5_r);
      end

      side7_r <= side6_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p7_r[i][j] <= PW2'(r6_r[i][j]) * PW2'(scl[j]);
        end
      end

      out_r.m00     <= sat(rnd(64'(p7_r[0][0])));
      out_r.m01     <= sat(rnd(64'(p7_r[0][1])));
      out_r.m02     <= sat(rnd(64'(p7_r[0][2])));
      out_r.m10     <= sat(rnd(64'(p7_r[1][0])));
      out_r.m11     <= sat(rnd(64'(p7_r[1][1])));
      out_r.m12     <= sat(rnd(64'(p7_r[1][2])));
      out_r.m20     <= sat(rnd(64'(p7_r[2][0])));
      out_r.m21     <= sat(rnd(64'(p7_r[2][1])));
      out_r.m22     <= sat(rnd(64'(p7_r[2][2])));
      out_r.trans_x <= side7_r.start_x;
      out_r.trans_y <= side7_r.start_y;
      out_r.trans_z <= side7_r.start_z;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== src/segment_model_matrix.sv =====
// top level: segment to model matrix pipeline
//
//  channel | ports                          | transaction
//  --------+--------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_data    | one segment
//  output  | out_valid, out_stall, out_data | top three rows of T*R*S
//
// one segment per cycle while out_stall does not hold the pipeline
// the square root and divider produce one result bit per stage
// synchronous active-low reset clears the valid line only
// the whole pipeline holds while a result waits on out_stall
`default_nettype none
module segment_model_matrix import smm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int TH      = ((1 << FRAC_BITS) + 999) / 1000;
  localparam int TW      = $clog2(TH + 1);
  localparam int TH2     = TH * TH;
  localparam int SQ_OUT  = SQ_IN_W / 2;
  localparam int SQ_LAT  = SQ_OUT + 1;
  localparam int DV_LAT  = FRAC_BITS + 2;
  localparam int SIDE_D  = 6 + SQ_LAT + DV_LAT;
  localparam int LAT     = SIDE_D + 8;
  localparam int CW      = FRAC_BITS + 2;
  localparam int NUM_W   = SQ_OUT;

  logic en;
  logic [LAT-1:0] vld_r;

  logic signed [DIR_W-1:0] dx_r, dy_r, dz_r;
  logic [DIR_W-1:0] mx_nxt, my_nxt, mz_nxt, m_nxt;
  logic [DIR_W-1:0] mx2_r, my2_r, mz2_r, m2_r;
  logic [DIR_W-1:0] mx3_r, my3_r, mz3_r;
  logic [2:0] sg2_r, sg3_r, sg4_r, sg5_r, sg6_r;
  logic small_nxt, small2_r, small3_r, small4_r, small5_r, ident6_r;
  logic [2*TW:0] hsum;
  logic [5:0] p_nxt, p3_r;
  logic [NRM_W-1:0] nx_nxt, ny_nxt, nz_nxt;
  logic [NRM_W-1:0] nx4_r, ny4_r, nz4_r, nx5_r, ny5_r, nz5_r, nx6_r, ny6_r, nz6_r;
  logic [2*NRM_W-1:0] sqx5_r, sqy5_r, sqz5_r;
  logic [SQ_IN_W-1:0] a2_r, l2_r;
  logic [SQ_OUT-1:0] a_root, l_root, den_a, den_l;
  logic [3*NRM_W+3:0] sq_side;
  logic [NRM_W-1:0] nx_s, ny_s, nz_s;
  logic [2:0] sg_s;
  logic ident_s;
  logic [3:0] dv_side;
  logic [FRAC_BITS:0] cq, sq, kxq, kzq;
  logic signed [CW-1:0] c_v, s_v, kx_v, kz_v;
  side_t side_in, side_rot;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    side_in.start_x      = in_data.start_x;
    side_in.start_y      = in_data.start_y;
    side_in.start_z      = in_data.start_z;
    side_in.radial_scale = in_data.radial_scale;
    side_in.length_scale = in_data.length_scale;
  end

  smm_delay #(.W($bits(side_t)), .D(SIDE_D)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (side_in),
    .q   (side_rot)
  );

  always_comb begin
    mx_nxt = dx_r[DIR_W-1] ? DIR_W'(-dx_r) : DIR_W'(dx_r);
    my_nxt = dy_r[DIR_W-1] ? DIR_W'(-dy_r) : DIR_W'(dy_r);
    mz_nxt = dz_r[DIR_W-1] ? DIR_W'(-dz_r) : DIR_W'(dz_r);
    m_nxt = mx_nxt;
    if (my_nxt > m_nxt) begin
      m_nxt = my_nxt;
    end
    if (mz_nxt > m_nxt) begin
      m_nxt = mz_nxt;
    end
    hsum = (2*TW+1)'(mx_nxt[TW-1:0]) * (2*TW+1)'(mx_nxt[TW-1:0])
         + (2*TW+1)'(mz_nxt[TW-1:0]) * (2*TW+1)'(mz_nxt[TW-1:0]);
    small_nxt = (mx_nxt < DIR_W'(TH)) && (mz_nxt < DIR_W'(TH))
             && (hsum < (2*TW+1)'(TH2));
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < DIR_W; i++) begin
      if (m2_r[i]) begin
        p_nxt = 6'(i);
      end
    end
  end

  always_comb begin
    if (p3_r < 6'(NORM_BIT)) begin
      nx_nxt = NRM_W'(mx3_r << (6'(NORM_BIT) - p3_r));
      ny_nxt = NRM_W'(my3_r << (6'(NORM_BIT) - p3_r));
      nz_nxt = NRM_W'(mz3_r << (6'(NORM_BIT) - p3_r));
    end else begin
      nx_nxt = NRM_W'(mx3_r >> (p3_r - 6'(NORM_BIT)));
      ny_nxt = NRM_W'(my3_r >> (p3_r - 6'(NORM_BIT)));
      nz_nxt = NRM_W'(mz3_r >> (p3_r - 6'(NORM_BIT)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DIR_W'(in_data.end_x) - DIR_W'(in_data.start_x);
      dy_r <= DIR_W'(in_data.end_y) - DIR_W'(in_data.start_y);
      dz_r <= DIR_W'(in_data.end_z) - DIR_W'(in_data.start_z);

      mx2_r    <= mx_nxt;
      my2_r    <= my_nxt;
      mz2_r    <= mz_nxt;
      m2_r     <= m_nxt;
      sg2_r    <= {dx_r[DIR_W-1], dy_r[DIR_W-1], dz_r[DIR_W-1]};
      small2_r <= small_nxt;

      mx3_r    <= mx2_r;
      my3_r    <= my2_r;
      mz3_r    <= mz2_r;
      p3_r     <= p_nxt;
      sg3_r    <= sg2_r;
      small3_r <= small2_r;

      nx4_r    <= nx_nxt;
      ny4_r    <= ny_nxt;
      nz4_r    <= nz_nxt;
      sg4_r    <= sg3_r;
      small4_r <= small3_r;

      sqx5_r   <= (2*NRM_W)'(nx4_r) * (2*NRM_W)'(nx4_r);
      sqy5_r   <= (2*NRM_W)'(ny4_r) * (2*NRM_W)'(ny4_r);
      sqz5_r   <= (2*NRM_W)'(nz4_r) * (2*NRM_W)'(nz4_r);
      nx5_r    <= nx4_r;
      ny5_r    <= ny4_r;
      nz5_r    <= nz4_r;
      sg5_r    <= sg4_r;
      small5_r <= small4_r;

      a2_r     <= SQ_IN_W'(sqx5_r) + SQ_IN_W'(sqz5_r);
      l2_r     <= SQ_IN_W'(sqx5_r) + SQ_IN_W'(sqy5_r) + SQ_IN_W'(sqz5_r);
      ident6_r <= small5_r || ((sqx5_r == '0) && (sqz5_r == '0));
      nx6_r    <= nx5_r;
      ny6_r    <= ny5_r;
      nz6_r    <= nz5_r;
      sg6_r    <= sg5_r;
    end
  end

  smm_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .v    (a2_r),
    .root (a_root)
  );

  smm_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_l (
    .clk  (clk),
    .en   (en),
    .v    (l2_r),
    .root (l_root)
  );

  smm_delay #(.W(3*NRM_W+4), .D(SQ_LAT)) u_sq_dly (
    .clk (clk),
    .en  (en),
    .d   ({nx6_r, ny6_r, nz6_r, sg6_r, ident6_r}),
    .q   (sq_side)
  );

  assign {nx_s, ny_s, nz_s, sg_s, ident_s} = sq_side;
  assign den_a = (a_root == '0) ? SQ_OUT'(1) : a_root;
  assign den_l = (l_root == '0) ? SQ_OUT'(1) : l_root;

  smm_div #(.NUM_W(NUM_W), .DEN_W(SQ_OUT), .F(FRAC_BITS)) u_div_c (
    .clk (clk), .en (en), .num (NUM_W'(ny_s)), .den (den_l), .quo (cq)
  );

  smm_div #(.NUM_W(NUM_W), .DEN_W(SQ_OUT), .F(FRAC_BITS)) u_div_s (
    .clk (clk), .en (en), .num (a_root), .den (den_l), .quo (sq)
  );

  smm_div #(.NUM_W(NUM_W), .DEN_W(SQ_OUT), .F(FRAC_BITS)) u_div_kx (
    .clk (clk), .en (en), .num (NUM_W'(nz_s)), .den (den_a), .quo (kxq)
  );

  smm_div #(.NUM_W(NUM_W), .DEN_W(SQ_OUT), .F(FRAC_BITS)) u_div_kz (
    .clk (clk), .en (en), .num (NUM_W'(nx_s)), .den (den_a), .quo (kzq)
  );

  // sign bits are x, y, z from high to low; kz takes the negated x sign
  smm_delay #(.W(4), .D(DV_LAT)) u_dv_dly (
    .clk (clk),
    .en  (en),
    .d   ({sg_s, ident_s}),
    .q   (dv_side)
  );

  assign c_v  = dv_side[2] ? -CW'(cq)  : CW'(cq);
  assign s_v  = CW'(sq);
  assign kx_v = dv_side[1] ? -CW'(kxq) : CW'(kxq);
  assign kz_v = dv_side[3] ? CW'(kzq)  : -CW'(kzq);

  smm_rot #(.F(FRAC_BITS)) u_rot (
    .clk      (clk),
    .en       (en),
    .c        (c_v),
    .s        (s_v),
    .kx       (kx_v),
    .kz       (kz_v),
    .ident    (dv_side[0]),
    .side     (side_rot),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench of the segment model matrix pipeline with a bit-exact predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import smm_pkg::*;

  localparam int FB = 16;
  localparam longint ONE_Q = 64'sd1 <<< FB;
  localparam longint HALF_Q = 64'sd1 <<< (FB - 1);
  localparam longint TH_Q = (ONE_Q + 999) / 1000;
  localparam int LATENCY = 64;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  segment_model_matrix #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  out_t matrix_q[$];
  int   mismatches = 0;
  int   sent = 0;
  int   received = 0;
  bit   idle_en = 1'b1;
  bit   hold_off = 1'b0;

  function automatic longint round_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + HALF_Q) >>> FB;
    return -((-p + HALF_Q) >>> FB);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint n;
    n = num * ONE_Q;
    if (n >= 0) return (n + den / 2) / den;
    return -((-n + den / 2) / den);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic out_t segment_matrix(in_t s);
    longint dx, dy, dz, m, a, l, c, sn, kx, kz, w, wkx, off;
    longint unsigned a2;
    longint r[3][3];
    longint sc[3];
    out_t o;
    dx = longint'(s.end_x) - longint'(s.start_x);
    dy = longint'(s.end_y) - longint'(s.start_y);
    dz = longint'(s.end_z) - longint'(s.start_z);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i][j] = (i == j) ? ONE_Q : 0;
    if (!(mag(dx) < TH_Q && mag(dz) < TH_Q && dx * dx + dz * dz < TH_Q * TH_Q)) begin
      m = mag(dx);
      if (mag(dy) > m) m = mag(dy);
      if (mag(dz) > m) m = mag(dz);
      while (m < (64'sd1 <<< 29)) begin
        dx = dx * 2; dy = dy * 2; dz = dz * 2; m = m * 2;
      end
      while (m >= (64'sd1 <<< 30)) begin
        dx = dx / 2; dy = dy / 2; dz = dz / 2; m = m / 2;
      end
      a2 = longint'(dx * dx) + longint'(dz * dz);
      if (a2 != 0) begin
        a = int_sqrt(a2);
        l = int_sqrt(a2 + longint'(dy * dy));
        c = round_div(dy, l);
        sn = round_div(a, l);
        kx = round_div(dz, a);
        kz = round_div(-dx, a);
        w = ONE_Q - c;
        wkx = round_mul(w, kx);
        off = round_mul(wkx, kz);
        r[0][0] = c + round_mul(wkx, kx);
        r[0][1] = -round_mul(sn, kz);
        r[0][2] = off;
        r[1][0] = round_mul(sn, kz);
        r[1][1] = c;
        r[1][2] = -round_mul(sn, kx);
        r[2][0] = off;
        r[2][1] = round_mul(sn, kx);
        r[2][2] = c + round_mul(round_mul(w, kz), kz);
      end
    end
    sc[0] = s.radial_scale; sc[1] = s.length_scale; sc[2] = s.radial_scale;
    o.m00 = clamp32(round_mul(r[0][0], sc[0]));
    o.m01 = clamp32(round_mul(r[0][1], sc[1]));
    o.m02 = clamp32(round_mul(r[0][2], sc[2]));
    o.m10 = clamp32(round_mul(r[1][0], sc[0]));
    o.m11 = clamp32(round_mul(r[1][1], sc[1]));
    o.m12 = clamp32(round_mul(r[1][2], sc[2]));
    o.m20 = clamp32(round_mul(r[2][0], sc[0]));
    o.m21 = clamp32(round_mul(r[2][1], sc[1]));
    o.m22 = clamp32(round_mul(r[2][2], sc[2]));
    o.trans_x = s.start_x;
    o.trans_y = s.start_y;
    o.trans_z = s.start_z;
    return o;
  endfunction

  // send one segment, prediction taken at acceptance
  task automatic send_segment(in_t s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    matrix_q.push_back(segment_matrix(s));
    sent++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $signed($urandom_range(0, 400)) - 200;
      3: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_segment(int kind);
    in_t s;
    s.start_x = rand_word(); s.start_y = rand_word(); s.start_z = rand_word();
    s.end_x = rand_word(); s.end_y = rand_word(); s.end_z = rand_word();
    s.radial_scale = rand_word(); s.length_scale = rand_word();
    if (kind == 1) begin
      // near vertical or short segment
      s.end_x = s.start_x + ($signed($urandom_range(0, 140)) - 70);
      s.end_z = s.start_z + ($signed($urandom_range(0, 140)) - 70);
    end else if (kind == 2) begin
      s.end_x = s.start_x + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      s.end_y = s.start_y + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      s.end_z = s.start_z + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      s.radial_scale = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      s.length_scale = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    end
    return s;
  endfunction

  function automatic in_t make_segment(int x0, int y0, int z0, int x1, int y1, int z1,
                                       int rs, int ls);
    in_t s;
    s.start_x = x0; s.start_y = y0; s.start_z = z0;
    s.end_x = x1; s.end_y = y1; s.end_z = z1;
    s.radial_scale = rs; s.length_scale = ls;
    return s;
  endfunction

  task automatic test_directed();
    int one;
    one = 32'h0001_0000;
    send_segment(make_segment(0, 0, 0, 0, 0, 0, one, one));
    send_segment(make_segment(0, 0, 0, 0, one, 0, 2 * one, 3 * one));
    send_segment(make_segment(5, 6, 7, 5, 6 - one, 7, one, one));
    send_segment(make_segment(0, 0, 0, 65, 0, 0, one, one));
    send_segment(make_segment(0, 0, 0, 66, 0, 0, one, one));
    send_segment(make_segment(0, 0, 0, 46, 0, 47, one, one));
    send_segment(make_segment(0, 0, 0, one, 0, 0, one, one));
    send_segment(make_segment(0, 0, 0, 0, 0, -one, one, one));
    send_segment(make_segment(0, 0, 0, one, one, one, one, one));
    send_segment(make_segment(0, 0, 0, -one, -one, one, -one, one));
    send_segment(make_segment(32'sh80000000, 32'sh80000000, 32'sh80000000,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh7fffffff, 32'sh80000000));
    send_segment(make_segment(32'sh7fffffff, 0, 32'sh7fffffff,
                              32'sh80000000, 0, 32'sh80000000,
                              32'sh80000000, 32'sh7fffffff));
    send_segment(make_segment(0, 0, 0, 1, 0, 0, one, one));
    send_segment(make_segment(0, 0, 0, 0, 32'sh7fffffff, 0,
                              32'sh7fffffff, 32'sh7fffffff));
    send_segment(make_segment(-1, -1, -1, -1, -1, -1, 0, 0));
    send_segment(make_segment(0, 0, 0, one, 0, one, 32'sh7fffffff, 32'sh80000000));
    send_segment(make_segment(0, 0, 0, 32'h3000_0000, 1, 0, one, one));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_segment(random_segment($urandom_range(0, 2)));
  endtask

  task automatic test_backpressure();
    hold_off <= 1'b1;
    for (int i = 0; i < 120; i++)
      send_segment(random_segment(2));
  endtask

  task automatic test_full_rate(int count);
    idle_en = 1'b0;
    for (int i = 0; i < count; i++)
      send_segment(random_segment($urandom_range(0, 2)));
  endtask

  // receiver stall
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    out_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_data);
      end else begin
        exp_m = matrix_q.pop_front();
        if (exp_m !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d: exp %h got %h", received, exp_m, out_data);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[segment_model_matrix] ERROR");
    $finish;
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300);
    test_backpressure();
    test_random(200);
    test_full_rate(300);
    in_valid <= 1'b0;
    waited = 0;
    while (matrix_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (matrix_q.size() != 0) mismatches++;
    $display("sent %0d segments, checked %0d matrices", sent, received);
    $display("covered vertical, short, extreme and random segments with stalls");
    if (mismatches == 0) begin
      $display("[segment_model_matrix] OK");
    end else begin
      $display("[segment_model_matrix] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/smm_pkg.sv
src/smm_delay.sv
src/smm_sqrt.sv
src/smm_div.sv
src/smm_rot.sv
src/segment_model_matrix.sv
tb/tb.sv
